// File: hdl/rgb555_palette_fade_engine_macros.svh
// ---------------------------------------------------------------------------
// RGB555 palette fade engine - assertion macros
// Concurrent assertion helpers shared by the engine's modules.
// ---------------------------------------------------------------------------
`ifndef RGB555_PALETTE_FADE_ENGINE_MACROS_SVH
`define RGB555_PALETTE_FADE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset
`define RPF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset
`define RPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset
`define RPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPF_ASSERT(label, clk, rst_n, prop, msg)
`define RPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/rpf_pkg.sv
// ---------------------------------------------------------------------------
// RGB555 palette fade engine - package
// Shared types, codes, the speed table and the weight function.
// ---------------------------------------------------------------------------
package rpf_pkg;

  // Palette size; entries at or above it are never written
  localparam int PALETTE_ENTRIES = 512;

  localparam int COLOUR_W  = 16;
  localparam int INDEX_W   = 9;
  localparam int WEIGHT_W  = 6;
  localparam int ALPHA_W   = 18;
  localparam int STEP_W    = 12;
  localparam int FRAMES_W  = 8;
  localparam int CFG_DATA_W = 3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 6'd32;
  localparam logic [ALPHA_W-1:0]  ALPHA_LINEAR_LIMIT = 18'h100;

  // Request codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_BLEND = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FADE_SPEED    = 1'b0;
  localparam logic CFG_INCLUDE_FIRST = 1'b1;

  // Number of speed table entries
  localparam logic [2:0] SPEED_COUNT = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ARMED  = 2'd1,
    PH_FADING = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [INDEX_W-1:0]  colour_index;
    logic [COLOUR_W-1:0] target_colour;
    logic [COLOUR_W-1:0] current_colour;
  } item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_now;
    logic [WEIGHT_W-1:0] weight_after;
    phase_t              phase_after;
    logic                finished;
  } fade_status_t;

  // Frame count for a speed selection
  function automatic logic [FRAMES_W-1:0] speed_frames(input logic [2:0] sel);
    logic [FRAMES_W-1:0] f;
    unique case (sel)
      3'd0:    f = 8'd8;
      3'd1:    f = 8'd16;
      3'd2:    f = 8'd32;
      3'd3:    f = 8'd64;
      3'd4:    f = 8'd128;
      default: f = '0;
    endcase
    return f;
  endfunction

  // Alpha step for a speed selection
  function automatic logic [STEP_W-1:0] speed_step(input logic [2:0] sel);
    logic [STEP_W-1:0] s;
    unique case (sel)
      3'd0:    s = 12'h004;
      3'd1:    s = 12'h002;
      3'd2:    s = 12'h001;
      3'd3:    s = 12'h800;
      3'd4:    s = 12'h400;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Blend weight: alpha itself below the linear limit, else its top bits; cap at 32
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [ALPHA_W-1:0] a);
    logic [ALPHA_W-1:0] w;
    w = (a < ALPHA_LINEAR_LIMIT) ? a : {12'd0, a[ALPHA_W-1:12]};
    return (w > ALPHA_W'(WEIGHT_MAX)) ? WEIGHT_MAX : w[WEIGHT_W-1:0];
  endfunction

endpackage

// File: hdl/rpf_in_reg.sv
// ---------------------------------------------------------------------------
// RGB555 palette fade engine - input register
// Captures one request from the input stream and holds it until the
// processing stage takes it.
// ---------------------------------------------------------------------------
module rpf_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [47:0]     in_tdata,   // colour_index, target_colour, current_colour, zero fill
  input  logic [1:0]      in_tuser,   // func
  input  logic            down_ready,
  output logic            item_valid,
  output rpf_pkg::item_t  item
);

  logic           valid_r;
  logic           valid_nxt;
  rpf_pkg::item_t item_r;

  // Accept when empty or when the held request moves on this cycle
  assign in_tready = !valid_r || down_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload on acceptance
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func           <= in_tuser;
      item_r.colour_index   <= in_tdata[8:0];
      item_r.target_colour  <= in_tdata[24:9];
      item_r.current_colour <= in_tdata[40:25];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: hdl/rpf_fade_ctrl.sv
// ---------------------------------------------------------------------------
// RGB555 palette fade engine - fade control
// Phase machine, frame countdown and alpha accumulator; reports the blend
// weight before and after each request.
// ---------------------------------------------------------------------------
`include "rgb555_palette_fade_engine_macros.svh"

module rpf_fade_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [1:0]            func,
  input  logic [2:0]            fade_speed,
  output rpf_pkg::fade_status_t status
);

  rpf_pkg::phase_t                 phase_r, phase_nxt;
  logic [rpf_pkg::FRAMES_W-1:0]    frames_r, frames_nxt;
  logic [rpf_pkg::ALPHA_W-1:0]     alpha_r, alpha_nxt;
  logic [rpf_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                            fin;

  // Advance the state only when a request moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rpf_pkg::PH_IDLE;
      frames_r <= '0;
      alpha_r  <= '0;
      step_r   <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      frames_r <= frames_nxt;
      alpha_r  <= alpha_nxt;
      step_r   <= step_nxt;
    end
  end

  // Next state for the request at the head of the pipe
  always_comb begin
    phase_nxt  = phase_r;
    frames_nxt = frames_r;
    alpha_nxt  = alpha_r;
    step_nxt   = step_r;
    fin        = 1'b0;
    unique case (func)
      rpf_pkg::FUNC_START: begin
        // restart unless already armed or the speed is out of the table
        if (phase_r != rpf_pkg::PH_ARMED && fade_speed < rpf_pkg::SPEED_COUNT) begin
          phase_nxt  = rpf_pkg::PH_ARMED;
          frames_nxt = rpf_pkg::speed_frames(fade_speed);
          step_nxt   = rpf_pkg::speed_step(fade_speed);
          alpha_nxt  = '0;
        end
      end
      rpf_pkg::FUNC_TICK: begin
        unique case (phase_r)
          rpf_pkg::PH_ARMED: begin
            phase_nxt = rpf_pkg::PH_FADING;
          end
          rpf_pkg::PH_FADING: begin
            if (frames_r != '0) begin
              alpha_nxt  = alpha_r + rpf_pkg::ALPHA_W'(step_r);
              frames_nxt = frames_r - 8'd1;
            end else begin
              phase_nxt = rpf_pkg::PH_IDLE;
              fin       = 1'b1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      default: begin
        // colour and unused requests leave the state alone
        phase_nxt = phase_r;
      end
    endcase
  end

  assign status.weight_now   = rpf_pkg::weight_of(alpha_r);
  assign status.weight_after = rpf_pkg::weight_of(alpha_nxt);
  assign status.phase_after  = phase_nxt;
  assign status.finished     = fin;

  `RPF_ASSERT_IMPL(a_fin_goes_idle, clk, rst_n, fin, phase_nxt == rpf_pkg::PH_IDLE,
    "fade end must return to idle")
  `RPF_ASSERT_NEXT(a_armed_tick, clk, rst_n,
    adv && func == rpf_pkg::FUNC_TICK && phase_r == rpf_pkg::PH_ARMED,
    phase_r == rpf_pkg::PH_FADING, "tick while armed must start fading")
  `RPF_ASSERT(a_frames_range, clk, rst_n, frames_r <= 8'd128,
    "frame countdown beyond table maximum")
  `RPF_ASSERT_NEXT(a_hold_without_adv, clk, rst_n, !adv,
    $stable(alpha_r) && $stable(frames_r), "state changed without a request")

endmodule

// File: hdl/rpf_blend.sv
// ---------------------------------------------------------------------------
// RGB555 palette fade engine - colour blend
// Per-channel weighted mix of current and target colour and the palette
// write qualifier.
// ---------------------------------------------------------------------------
module rpf_blend (
  input  rpf_pkg::item_t                item,
  input  logic [rpf_pkg::WEIGHT_W-1:0]  weight,
  input  logic                          include_first,
  output logic [rpf_pkg::COLOUR_W-1:0]  blended_colour,
  output logic                          write_enable
);

  logic [rpf_pkg::WEIGHT_W-1:0] inv_w;
  logic [4:0]                   mix [3];
  logic                         is_blend;
  logic                         in_range;

  assign inv_w    = rpf_pkg::WEIGHT_MAX - weight;
  assign is_blend = (item.func == rpf_pkg::FUNC_BLEND);

  // Mix each 5-bit channel with rounding
  always_comb begin
    logic [11:0] acc;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 12'(item.current_colour[ch*5 +: 5]) * 12'(inv_w)
          + 12'(item.target_colour[ch*5 +: 5]) * 12'(weight)
          + 12'd16;
      mix[ch] = acc[9:5];
    end
  end

  // Pass equal colours through whole, including bit 15
  always_comb begin
    blended_colour = '0;
    if (is_blend) begin
      if (item.target_colour == item.current_colour) begin
        blended_colour = item.target_colour;
      end else begin
        blended_colour = {1'b0, mix[2], mix[1], mix[0]};
      end
    end
  end

  // Skip slot zero of each bank unless enabled; drop out-of-range entries
  assign in_range     = {1'b0, item.colour_index} < 10'(rpf_pkg::PALETTE_ENTRIES);
  assign write_enable = is_blend && in_range &&
                        (include_first || item.colour_index[3:0] != 4'd0);

endmodule

// File: hdl/rgb555_palette_fade_engine.sv
// ---------------------------------------------------------------------------
// RGB555 palette fade engine - top level
// Palette fade control and per-colour blend with a registered result.
//
//   channel  dir  handshake          tdata / tuser / tlast
//   in_      in   in_tvalid/tready   idx, target, current / func / -
//   out_     out  out_tvalid/tready  colour, we, weight, phase / - / finished
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One request per cycle while the output is not stalled; each passes through
// the input register, then the fade state update and blend into the output
// register. Reset is synchronous and clears config and fade state. A stalled
// output holds its result and the input register, and back-pressure reaches
// in_tready in the same cycle.
// ---------------------------------------------------------------------------
module rgb555_palette_fade_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // colour_index[8:0], target_colour[24:9],
                                  // current_colour[40:25], zero[47:41]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // blended_colour[15:0], write_enable[16],
                                  // weight[22:17], phase[24:23], zero[31:25]
  output logic        out_tlast,  // finished
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [rpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                          item_valid;
  rpf_pkg::item_t                item;
  logic                          down_ready;
  logic                          adv;
  rpf_pkg::fade_status_t         status;
  logic [rpf_pkg::COLOUR_W-1:0]  blended_colour;
  logic                          write_enable;

  logic [2:0]  fade_speed_r;
  logic        include_first_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_speed_r    <= '0;
      include_first_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpf_pkg::CFG_FADE_SPEED:    fade_speed_r    <= cfg_wdata;
        rpf_pkg::CFG_INCLUDE_FIRST: include_first_r <= cfg_wdata[0];
        default:                    fade_speed_r    <= fade_speed_r;
      endcase
    end
  end

  rpf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .down_ready (down_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  // Output register is free when empty or being drained
  assign down_ready = !out_valid_r || out_tready;
  assign adv        = item_valid && down_ready;

  rpf_fade_ctrl u_fade_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .func       (item.func),
    .fade_speed (fade_speed_r),
    .status     (status)
  );

  rpf_blend u_blend (
    .item           (item),
    .weight         (status.weight_now),
    .include_first  (include_first_r),
    .blended_colour (blended_colour),
    .write_enable   (write_enable)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (down_ready) begin
      out_valid_nxt = item_valid;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {7'd0, status.phase_after, status.weight_after,
                     write_enable, blended_colour};
      out_last_r <= status.finished;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: tb/sv/rgb555_palette_fade_engine_test.sv
// ---------------------------------------------------------------------------
// RGB555 palette fade engine - self-checking testbench
// Drives start, tick, blend and unused requests into the engine through a
// stream handshake and predicts each result with a cycle-free model of the
// fade state and per-channel blend, unless a directed row gives its own. A
// short directed table, then random fade runs at every speed, gapped on both sides.
// ---------------------------------------------------------------------------
module rgb555_palette_fade_engine_test;
  import rpf_pkg::*;

  localparam int          RANDOM_ITEMS = 450;
  localparam int          STALL_LIMIT  = 2000;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

  typedef struct packed {
    logic [15:0] colour;
    logic        we;
    logic [5:0]  weight;
    phase_t      phase;
    logic        fin;
  } fade_result_t;

  typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   func;
    logic [8:0]   idx;
    logic [15:0]  tgt;
    logic [15:0]  cur;
    logic         reg_sel;
    logic [2:0]   reg_val;
    logic         typed;
    fade_result_t want;
  } stim_row_t;

  typedef struct packed {
    logic         typed;
    fade_result_t want;
  } answer_note_t;

  localparam fade_result_t NO_RESULT = '0;
  localparam int DIRECTED_ROWS = 25;

  // kind, func, index, target, current, register, value, typed, expected result
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_REQUEST, FUNC_BLEND, 9'd0, 16'h7FFF, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'h0000, 1'b0, 6'd0, PH_IDLE, 1'b0}},
    '{ROW_REQUEST, FUNC_BLEND, 9'd511, 16'hFFFF, 16'hFFFF, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'hFFFF, 1'b1, 6'd0, PH_IDLE, 1'b0}},
    '{ROW_REQUEST, FUNC_TICK, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'h0000, 1'b0, 6'd0, PH_IDLE, 1'b0}},
    '{ROW_REQUEST, FUNC_UNUSED, 9'h1FF, 16'hFFFF, 16'hFFFF, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'h0000, 1'b0, 6'd0, PH_IDLE, 1'b0}},
    '{ROW_REG_WRITE, FUNC_START, 9'd0, 16'h0, 16'h0, CFG_FADE_SPEED, 3'd7, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_START, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'h0000, 1'b0, 6'd0, PH_IDLE, 1'b0}},
    '{ROW_REG_WRITE, FUNC_START, 9'd0, 16'h0, 16'h0, CFG_INCLUDE_FIRST, 3'd1, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_BLEND, 9'd16, 16'h1234, 16'h5678, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REG_WRITE, FUNC_START, 9'd0, 16'h0, 16'h0, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_START, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'h0000, 1'b0, 6'd0, PH_ARMED, 1'b0}},
    '{ROW_REQUEST, FUNC_START, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'h0000, 1'b0, 6'd0, PH_ARMED, 1'b0}},
    '{ROW_REQUEST, FUNC_TICK, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b1,
      '{16'h0000, 1'b0, 6'd0, PH_FADING, 1'b0}},
    '{ROW_REQUEST, FUNC_TICK, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_BLEND, 9'h1F0, 16'h7FFF, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_START, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_TICK, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REG_WRITE, FUNC_START, 9'd0, 16'h0, 16'h0, CFG_FADE_SPEED, 3'd4, 1'b0, NO_RESULT},
    '{ROW_REG_WRITE, FUNC_START, 9'd0, 16'h0, 16'h0, CFG_INCLUDE_FIRST, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_START, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_TICK, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_TICK, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_TICK, 9'd0, 16'h0000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_BLEND, 9'd32, 16'h8000, 16'h0000, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_BLEND, 9'h155, 16'h2A55, 16'h2A55, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT},
    '{ROW_REQUEST, FUNC_UNUSED, 9'h0AA, 16'h1234, 16'h4321, CFG_FADE_SPEED, 3'd0, 1'b0, NO_RESULT}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted engine state and registers
  phase_t      fade_ph;
  logic [7:0]  frames_cnt;
  logic [17:0] alpha_acc;
  logic [11:0] alpha_inc;
  logic [2:0]  speed_sel;
  logic        incl_first;

  fade_result_t expected_results [$];
  answer_note_t answer_notes [$];
  int           mismatches  = 0;
  int           idle_cycles = 0;
  int           sent        = 0;
  bit           quiet_src   = 1'b0;
  bit           quiet_sink  = 1'b0;
  int           stall_left  = 0;

  rgb555_palette_fade_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Speed table: frames per fade and alpha step per frame
  function automatic logic [7:0] frame_count(input logic [2:0] spd);
    case (spd)
      3'd0:    return 8'd8;
      3'd1:    return 8'd16;
      3'd2:    return 8'd32;
      3'd3:    return 8'd64;
      3'd4:    return 8'd128;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [11:0] alpha_increment(input logic [2:0] spd);
    case (spd)
      3'd0:    return 12'h004;
      3'd1:    return 12'h002;
      3'd2:    return 12'h001;
      3'd3:    return 12'h800;
      3'd4:    return 12'h400;
      default: return 12'h000;
    endcase
  endfunction

  // Small alpha is the weight itself; large alpha uses its top bits; cap at 32
  function automatic logic [5:0] weight_from_alpha(input logic [17:0] a);
    logic [17:0] w;
    w = (a < 18'h100) ? a : (a >> 12);
    return (w > 18'd32) ? 6'd32 : w[5:0];
  endfunction

  function automatic logic [4:0] blend_lane(input int c, input int t, input int w);
    int mixed;
    mixed = (c * (32 - w) + t * w + 16) >> 5;
    return mixed[4:0];
  endfunction

  // Equal colours pass through whole, bit 15 included; otherwise mix each lane
  function automatic logic [15:0] fade_colour(input logic [15:0] tgt, input logic [15:0] cur,
                                              input logic [5:0] w);
    logic [15:0] mixed;
    mixed = '0;
    if (tgt == cur) return tgt;
    for (int lane = 0; lane < 3; lane++) begin
      mixed[lane*5 +: 5] = blend_lane(int'(cur[lane*5 +: 5]), int'(tgt[lane*5 +: 5]), int'(w));
    end
    return mixed;
  endfunction

  // Apply one request to the predicted state and return its result
  function automatic fade_result_t advance_fade(input logic [1:0] func, input logic [8:0] idx,
                                                input logic [15:0] tgt, input logic [15:0] cur);
    fade_result_t r;
    r = '0;
    case (func)
      FUNC_START: begin
        if (fade_ph != PH_ARMED && speed_sel < SPEED_COUNT) begin
          fade_ph    = PH_ARMED;
          frames_cnt = frame_count(speed_sel);
          alpha_inc  = alpha_increment(speed_sel);
          alpha_acc  = '0;
        end
      end
      FUNC_TICK: begin
        if (fade_ph == PH_ARMED) begin
          fade_ph = PH_FADING;
        end else if (fade_ph == PH_FADING) begin
          if (frames_cnt != 8'd0) begin
            alpha_acc  = alpha_acc + 18'(alpha_inc);
            frames_cnt = frames_cnt - 8'd1;
          end else begin
            fade_ph = PH_IDLE;
            r.fin   = 1'b1;
          end
        end
      end
      FUNC_BLEND: begin
        r.colour = fade_colour(tgt, cur, weight_from_alpha(alpha_acc));
        r.we     = (int'(idx) < PALETTE_ENTRIES) && (incl_first || idx[3:0] != 4'd0);
      end
      default: ;
    endcase
    r.weight = weight_from_alpha(alpha_acc);
    r.phase  = fade_ph;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none at all in a quiet stretch
  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Track registers, check results and predict new requests
  always @(posedge clk) begin : scoreboard
    fade_result_t want;
    answer_note_t note;
    if (!rst_n) begin
      fade_ph    = PH_IDLE;
      frames_cnt = '0;
      alpha_acc  = '0;
      alpha_inc  = '0;
      speed_sel  = '0;
      incl_first = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FADE_SPEED) speed_sel = cfg_wdata;
        else incl_first = cfg_wdata[0];
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[15:0] !== want.colour) begin
            $error("blended_colour: expected %h, got %h", want.colour, out_tdata[15:0]);
            mismatches++;
          end
          if (out_tdata[16] !== want.we) begin
            $error("write_enable: expected %0d, got %0d", want.we, out_tdata[16]);
            mismatches++;
          end
          if (out_tdata[22:17] !== want.weight) begin
            $error("weight: expected %0d, got %0d", want.weight, out_tdata[22:17]);
            mismatches++;
          end
          if (out_tdata[24:23] !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_tdata[24:23]);
            mismatches++;
          end
          if (out_tlast !== want.fin) begin
            $error("finished: expected %0d, got %0d", want.fin, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = advance_fade(in_tuser, in_tdata[8:0], in_tdata[24:9], in_tdata[40:25]);
        note = answer_notes.pop_front();
        if (note.typed) want = note.want;
        expected_results.push_back(want);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Stall the result channel at random, with quiet stretches now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) quiet_sink <= !quiet_sink;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len(quiet_sink);
    end
  end

  // Abort when nothing moves for too long
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("[rgb555_palette_fade_engine] ERROR");
    $finish;
  end

  // Present one request, hold it until accepted, then idle for the gap
  task automatic send_request(input logic [1:0] func, input logic [8:0] idx,
                              input logic [15:0] tgt, input logic [15:0] cur,
                              input logic typed, input fade_result_t want, input int gap);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'd0, cur, tgt, idx};
    answer_notes.push_back('{typed, want});
    do @(posedge clk); while (!in_tready);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [1:0] func);
    logic [15:0] t;
    logic [15:0] c;
    t = 16'($urandom);
    c = ($urandom_range(0, 7) == 0) ? t : 16'($urandom);
    send_request(func, 9'($urandom), t, c, 1'b0, NO_RESULT, gap_len(quiet_src));
    sent++;
  endtask

  // Hold the sender until every result is back and the pipeline is empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    // let the request accepted at this edge reach the queue first
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [2:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One fade run: set registers, start, then ticks mixed with blends, restarts and unused requests
  task automatic run_fade_phase();
    logic [2:0] spd;
    int         ticks_due;
    int         ticks;
    int         r;
    case ($urandom_range(0, 9))
      0, 1, 2: spd = 3'd0;
      3, 4:    spd = 3'd1;
      5, 6:    spd = 3'd2;
      7:       spd = 3'd3;
      8:       spd = 3'd4;
      default: spd = 3'($urandom_range(5, 7));
    endcase
    quiet_src = ($urandom_range(0, 3) == 0);
    drain_results();
    write_register(CFG_FADE_SPEED, spd);
    write_register(CFG_INCLUDE_FIRST, 3'($urandom_range(0, 1)));
    ticks_due = (spd < SPEED_COUNT) ? int'(frame_count(spd)) + 2 + $urandom_range(0, 2)
                                    : $urandom_range(2, 5);
    send_random(FUNC_START);
    ticks = 0;
    while (ticks < ticks_due && sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 199);
      if (r < 100) begin
        send_random(FUNC_TICK);
        ticks++;
      end else if (r < 186 || (r < 190 && spd >= 3'd2)) begin
        send_random(FUNC_BLEND);
      end else if (r < 190) begin
        send_random(FUNC_START);
        ticks = 0;
      end else begin
        send_random(FUNC_UNUSED);
      end
    end
  endtask

  initial begin
    stim_row_t row;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_REG_WRITE) begin
        drain_results();
        write_register(row.reg_sel, row.reg_val);
      end else begin
        send_request(row.func, row.idx, row.tgt, row.cur, row.typed, row.want,
                     gap_len(1'b0));
      end
    end

    // Random fade runs
    while (sent < RANDOM_ITEMS) run_fade_phase();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[rgb555_palette_fade_engine] OK");
    end else begin
      $display("[rgb555_palette_fade_engine] ERROR");
    end
    $finish;
  end

endmodule
